FILE: rtl/skpl_pkg.sv
// Package for the soft-knee peak limiter: field widths, register indexes and
// the log2 / exp2 interpolation tables.
// Depends on nothing; every other file of the block imports it.
package skpl_pkg;

    localparam int SampleW = 24;
    localparam int CoeffW  = 16;
    localparam int ThreshW = 15;
    localparam int KneeW   = 13;
    localparam int RatioW  = 9;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic [CfgIdxW-1:0] cfg_index_t;
    typedef logic [CfgDatW-1:0] cfg_data_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ATTACK    = 3'd0,
        REG_RELEASE   = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_KNEE      = 3'd3,
        REG_RATIO     = 3'd4
    } cfg_reg_t;

    localparam logic [CoeffW-1:0]  AttackReset    = 16'd65470;
    localparam logic [CoeffW-1:0]  ReleaseReset   = 16'd65529;
    localparam logic [ThreshW-1:0] ThresholdReset = 15'h7F00;
    localparam logic [KneeW-1:0]   KneeReset      = 13'd1536;
    localparam logic [RatioW-1:0]  RatioReset     = 9'd64;

    // 20*log10(2) in Q16, and log2(10)/20 in Q16.
    localparam logic [18:0] DbPerOctave = 19'd394566;
    localparam logic [13:0] OctPerDb    = 14'd10885;
    localparam logic signed [16:0] FloorDb = -17'sd51200;

    // log2(1+k/16) in Q16.
    localparam logic [16:0] LOG2_TAB [17] = '{
        17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30110, 17'd34313, 17'd38336, 17'd42196, 17'd45904, 17'd49473,
        17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    // 2^(-k/16) in Q16.
    localparam logic [16:0] EXP2_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52772,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

endpackage

FILE: rtl/skpl_ifs.sv
// Valid/ready channel interfaces of the soft-knee peak limiter: sample input,
// result output and register writes. Depends on skpl_pkg.
interface skpl_sample_if;
    import skpl_pkg::*;
    logic    valid;
    logic    ready;
    logic    channel;
    sample_t sample_in;
    modport source (output valid, output channel, output sample_in, input ready);
    modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface skpl_result_if;
    import skpl_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface skpl_cfg_if;
    import skpl_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/soft_knee_peak_limiter.sv
// Soft-knee feed-forward peak limiter, top level: envelope memory, sequencer,
// log/exp interpolation and the serial divider. Depends on skpl_pkg, skpl_ifs.
//
//   channel     role     beat contents
//   sample_ch   sink     channel, sample_in (Q3.20)
//   result_ch   source   sample_out (Q3.20)
//   cfg_ch      sink     index, data (register write)
//
// On the knee path an item passes the knee multiply and the sixteen quotient
// steps of the serial divider; the linear path skips the knee multiply, and
// with no reduction an item goes from the gain compare straight to the last
// step, as does a channel out of range from the read step. The result beat is
// raised in the same cycle that the next sample can be taken.
// Reset clears the envelope valid bits, so every envelope reads as zero.
// A stalled result holds the sequencer in its last step; new samples are
// taken once that result beat has gone.

module soft_knee_peak_limiter #(
    parameter int CHANNELS = 2
) (
    input logic clk,
    input logic rst_n,
    skpl_sample_if.sink   sample_ch,
    skpl_result_if.source result_ch,
    skpl_cfg_if.sink      cfg_ch
);
    import skpl_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_ENV_MUL, S_ENV_SUM, S_LOG_NORM, S_LOG_INTERP,
        S_LOG_DB, S_GR_CMP, S_KNEE_MUL, S_DIV, S_EXP_MUL, S_EXP_TAB,
        S_OUT_MUL, S_FINISH
    } state_t;

    // Configuration registers.
    logic [CoeffW-1:0]         attack_reg;
    logic [CoeffW-1:0]         release_reg;
    logic signed [ThreshW-1:0] thresh_reg;
    logic [KneeW-1:0]          knee_reg;
    logic [RatioW-1:0]         ratio_reg;

    // Sequencer state and item registers.
    state_t               state_reg;
    logic [AW-1:0]        ch_reg;
    logic                 pass_reg;
    logic                 neg_reg;
    logic [SampleW-1:0]   raw_reg;
    logic [SampleW-1:0]   mag_reg;
    logic [CHANNELS-1:0]  env_vld_reg;
    logic [SampleW-1:0]   env_reg;
    logic [39:0]          prod_a_reg;
    logic [40:0]          prod_b_reg;
    logic                 zero_reg;
    logic [4:0]           p_reg;
    logic [3:0]           k_reg;
    logic [18:0]          r_reg;
    logic signed [22:0]   l_reg;
    logic signed [16:0]   db_reg;
    logic [27:0]          sq_reg;
    logic [8:0]           slope_reg;
    logic [36:0]          rem_reg;
    logic [24:0]          den_reg;
    logic [39:0]          dsh_reg;
    logic [3:0]           cnt_reg;
    logic [15:0]          gr_reg;
    logic [21:0]          e_reg;
    logic [16:0]          g_reg;
    logic [40:0]          oprod_reg;
    logic                 out_vld_reg;
    logic [SampleW-1:0]   out_reg;

    // Envelope memory with a registered read port.
    logic [SampleW-1:0] env_mem [CHANNELS];
    logic [SampleW-1:0] rd_data_reg;

    // Combinational helpers.
    logic [SampleW-1:0] in_raw;
    logic [SampleW-1:0] in_mag;
    logic [SampleW-1:0] env_cur;
    logic [CoeffW-1:0]  coeff;
    logic [16:0]        coeff_inv;
    logic [41:0]        env_sum;
    logic [SampleW-1:0] env_new;
    logic [4:0]         lead_pos;
    logic [SampleW-1:0] norm;
    logic [16:0]        lt0;
    logic [16:0]        lt1;
    logic [31:0]        lprod;
    logic [16:0]        lfrac;
    logic signed [22:0] l_next;
    logic [21:0]        l_abs;
    logic [40:0]        dbprod;
    logic [16:0]        db_mag;
    logic signed [16:0] db_next;
    logic signed [18:0] d2;
    logic signed [18:0] t2;
    logic signed [18:0] high2;
    logic signed [18:0] low2;
    logic signed [17:0] d_lin;
    logic signed [18:0] y_knee;
    logic [24:0]        lin_num;
    logic [21:0]        kq;
    logic [39:0]        trial;
    logic               take;
    logic [29:0]        e_full;
    logic [4:0]         ek;
    logic [16:0]        gt0;
    logic [16:0]        gt1;
    logic [23:0]        gprod;
    logic [5:0]         n_int;
    logic [6:0]         sh;
    logic [57:0]        rnd_sum;
    logic [57:0]        res_full;
    logic [SampleW-1:0] res;
    logic [SampleW-1:0] out_next;
    logic               out_free;

    assign sample_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready     = 1'b1;
    assign result_ch.valid  = out_vld_reg;
    assign result_ch.sample_out = out_reg;
    assign out_free = !out_vld_reg || result_ch.ready;

    always_comb
    begin
        in_raw = sample_ch.sample_in;
        in_mag = in_raw[SampleW-1] ? SampleW'(0) - in_raw : in_raw;

        // Envelope update; an entry never written since reset reads as zero.
        env_cur   = env_vld_reg[ch_reg] ? rd_data_reg : '0;
        coeff     = (mag_reg > env_cur) ? attack_reg : release_reg;
        coeff_inv = 17'h10000 - {1'b0, coeff};
        env_sum   = 42'(prod_a_reg) + 42'(prod_b_reg) + 42'd32768;
        env_new   = env_sum[39:16];

        // Leading one and normalised mantissa of the envelope.
        lead_pos = '0;
        for (int i = 0; i < SampleW; i++)
        begin
            if (env_reg[i])
            begin
                lead_pos = 5'(i);
            end
        end
        norm = env_reg << (5'd23 - lead_pos);

        // log2 interpolation, Q16, less 20 for the Q3.20 scale.
        lt0    = LOG2_TAB[k_reg];
        lt1    = LOG2_TAB[5'(k_reg) + 5'd1];
        lprod  = 32'(lt1 - lt0) * 32'(r_reg);
        lfrac  = lt0 + 17'(lprod >> 19);
        l_next = $signed({1'b0, p_reg, 16'b0}) + $signed({6'b0, lfrac})
                 - 23'sd1310720;

        // Conversion to dB, rounded half away from zero.
        l_abs   = l_reg[22] ? 22'(-l_reg) : 22'(l_reg);
        dbprod  = 41'(l_abs) * 41'(DbPerOctave) + 41'd8388608;
        db_mag  = dbprod[40:24];
        db_next = zero_reg ? FloorDb :
                  (l_reg[22] ? -$signed(db_mag) : $signed(db_mag));

        // Knee edges, all doubled to keep the half knee exact.
        d2     = {db_reg[16], db_reg, 1'b0};
        t2     = {{3{thresh_reg[14]}}, thresh_reg, 1'b0};
        high2  = t2 + $signed({6'b0, knee_reg});
        low2   = t2 - $signed({6'b0, knee_reg});
        d_lin  = {db_reg[16], db_reg} - {{3{thresh_reg[14]}}, thresh_reg};
        y_knee = d2 - low2;
        lin_num = 25'(d_lin[15:0]) * 25'(ratio_reg - 9'd16);
        kq      = 22'(knee_reg) * 22'(ratio_reg);

        // One restoring quotient step.
        trial = 40'(rem_reg) - dsh_reg;
        take  = (40'(rem_reg) >= dsh_reg);

        // Gain exponent and exp2 interpolation.
        e_full = 30'(gr_reg) * 30'(OctPerDb) + 30'd128;
        ek     = {1'b0, e_reg[15:12]};
        gt0    = EXP2_TAB[ek];
        gt1    = EXP2_TAB[ek + 5'd1];
        gprod  = 24'(gt0 - gt1) * 24'(e_reg[11:0]);

        // Output rounding at 2^(16+n).
        n_int    = e_reg[21:16];
        sh       = 7'd16 + 7'(n_int);
        rnd_sum  = 58'(oprod_reg) + (58'd1 << (sh - 7'd1));
        res_full = rnd_sum >> sh;
        res      = (n_int > 6'd40) ? '0 : res_full[SampleW-1:0];
        if (gr_reg == '0)
        begin
            out_next = raw_reg;
        end
        else
        begin
            out_next = neg_reg ? SampleW'(0) - res : res;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= env_mem[ch_reg];
        if (state_reg == S_ENV_SUM)
        begin
            env_mem[ch_reg] <= env_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= AttackReset;
            release_reg <= ReleaseReset;
            thresh_reg  <= ThresholdReset;
            knee_reg    <= KneeReset;
            ratio_reg   <= RatioReset;
            state_reg   <= S_IDLE;
            env_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    REG_ATTACK:    attack_reg  <= cfg_ch.data;
                    REG_RELEASE:   release_reg <= cfg_ch.data;
                    REG_THRESHOLD: thresh_reg  <= cfg_ch.data[ThreshW-1:0];
                    REG_KNEE:      knee_reg    <= cfg_ch.data[KneeW-1:0];
                    REG_RATIO:     ratio_reg   <= cfg_ch.data[RatioW-1:0];
                    default:       ;
                endcase
            end

            // In the last step the result register is reloaded instead.
            if (out_vld_reg && result_ch.ready && state_reg != S_FINISH)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_ch.valid)
                    begin
                        ch_reg    <= AW'(sample_ch.channel);
                        pass_reg  <= ({31'b0, sample_ch.channel} >= 32'(CHANNELS));
                        raw_reg   <= in_raw;
                        neg_reg   <= in_raw[SampleW-1];
                        mag_reg   <= in_mag;
                        gr_reg    <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= pass_reg ? S_FINISH : S_ENV_MUL;
                end
                S_ENV_MUL:
                begin
                    prod_a_reg <= 40'(coeff) * 40'(env_cur);
                    prod_b_reg <= 41'(coeff_inv) * 41'(mag_reg);
                    state_reg  <= S_ENV_SUM;
                end
                S_ENV_SUM:
                begin
                    env_reg <= env_new;
                    env_vld_reg[ch_reg] <= 1'b1;
                    state_reg <= S_LOG_NORM;
                end
                S_LOG_NORM:
                begin
                    zero_reg  <= (env_reg == '0);
                    p_reg     <= lead_pos;
                    k_reg     <= norm[22:19];
                    r_reg     <= norm[18:0];
                    state_reg <= S_LOG_INTERP;
                end
                S_LOG_INTERP:
                begin
                    l_reg     <= l_next;
                    state_reg <= S_LOG_DB;
                end
                S_LOG_DB:
                begin
                    db_reg    <= db_next;
                    state_reg <= S_GR_CMP;
                end
                S_GR_CMP:
                begin
                    slope_reg <= ratio_reg - 9'd16;
                    sq_reg    <= 28'(y_knee[13:0]) * 28'(y_knee[13:0]);
                    cnt_reg   <= 4'd15;
                    if (ratio_reg <= 9'd16)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (d2 > high2)
                    begin
                        rem_reg   <= 37'(lin_num);
                        dsh_reg   <= 40'(ratio_reg) << 15;
                        state_reg <= S_DIV;
                    end
                    else if (d2 > low2 && knee_reg != '0)
                    begin
                        den_reg   <= {kq, 3'b0};
                        state_reg <= S_KNEE_MUL;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_KNEE_MUL:
                begin
                    rem_reg   <= 37'(sq_reg) * 37'(slope_reg);
                    dsh_reg   <= 40'(den_reg) << 15;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (take)
                    begin
                        rem_reg <= trial[36:0];
                    end
                    gr_reg  <= {gr_reg[14:0], take};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_EXP_MUL;
                    end
                end
                S_EXP_MUL:
                begin
                    e_reg     <= e_full[29:8];
                    state_reg <= S_EXP_TAB;
                end
                S_EXP_TAB:
                begin
                    g_reg     <= gt0 - 17'(gprod >> 12);
                    state_reg <= S_OUT_MUL;
                end
                S_OUT_MUL:
                begin
                    oprod_reg <= 41'(mag_reg) * 41'(g_reg);
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_reg     <= out_next;
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/skpl_checker.sv
// Port-level checks for the soft-knee peak limiter, bound to the top level.
// Depends on skpl_pkg and the top level's channel interfaces.
module skpl_assertions (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [skpl_pkg::SampleW-1:0] sample_out,
    input logic cfg_ready
);
    import skpl_pkg::*;

    // A result beat that is not taken stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("result beat dropped or changed while stalled");

    // One sample at a time: after a beat is taken the input stays closed
    // for the read step and the step that follows it.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("sample taken while another is in flight");

    // Register writes are never refused.
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind soft_knee_peak_limiter skpl_assertions u_skpl_assertions (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .sample_out (result_ch.sample_out),
    .cfg_ready  (cfg_ch.ready)
);
